// ----- design/mpr_pkg.sv -----
`default_nettype none

package mpr_pkg;

    // symbol space and length limits
    localparam int SYM_W      = 18;
    localparam int SYM_DEPTH  = 1 << SYM_W;
    localparam int CNT_W      = 19;
    localparam int LEN_W      = 19;
    localparam int MAX_LENGTH = 262144;

    // modular arithmetic
    localparam int MOD_W = 30;
    localparam int BIT_W = 5;
    localparam logic [MOD_W-1:0] PRIME   = 30'd998244353;
    localparam logic [MOD_W-1:0] EXP_INV = PRIME - 30'd2;

    typedef struct packed {
        logic             command;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } item_t;

    typedef struct packed {
        logic [MOD_W-1:0] rank;
        logic             halted;
    } result_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_L_CNT,
        S_L_INC,
        S_L_MD,
        S_L_MDW,
        S_L_MF,
        S_L_MFW,
        S_TR_RD,
        S_TR_WR,
        S_PW_SQ,
        S_PW_SQW,
        S_PW_CHK,
        S_PW_MLW,
        S_PW_NX,
        S_T_SUM,
        S_T_SRD,
        S_T_SACC,
        S_T_CNT,
        S_T_HAVE,
        S_T_TERM,
        S_T_T1W,
        S_T_T2,
        S_T_T2W,
        S_T_UPD,
        S_T_INV,
        S_T_INVW,
        S_RESULT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_CNT_RD,
        OP_CNT_INC,
        OP_HAVE,
        OP_CNT_DEC,
        OP_TREE_RD,
        OP_TREE_UPD,
        OP_SUM_INIT,
        OP_SUM_ACC,
        OP_POW_INIT,
        OP_EBIT_DEC,
        OP_MUL,
        OP_STOP,
        OP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        MS_DEN,
        MS_FACT,
        MS_SQ,
        MS_BASE,
        MS_TERM1,
        MS_TERM2,
        MS_INV
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t mul_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic cmd;
        logic load_skip;
        logic stopped;
        logic started;
        logic pos_end;
        logic pos_zero;
        logic exp_bit;
        logic ebit_zero;
        logic term_go;
        logic have_zero;
        logic mul_done;
        logic out_full;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- design/mpr_modmul.sv -----
`default_nettype none

// shift-add modular multiplier, one bit of b per cycle, msb first
module mpr_modmul
    import mpr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MOD_W-1:0] a,
    input  wire logic [MOD_W-1:0] b,
    output logic                  done,
    output logic      [MOD_W-1:0] p
);

    logic [MOD_W-1:0] a_reg;
    logic [MOD_W-1:0] b_reg;
    logic [MOD_W-1:0] acc_reg;
    logic [BIT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [MOD_W+1:0] dbl;
    logic [MOD_W+1:0] s1;
    logic [MOD_W+1:0] s2;

    // double, add, and two conditional subtracts keep acc below the prime
    always_comb
    begin
        dbl = {1'b0, acc_reg, 1'b0} + (b_reg[MOD_W-1] ? {2'b00, a_reg} : '0);
        s1  = (dbl >= {2'b00, PRIME}) ? dbl - {2'b00, PRIME} : dbl;
        s2  = (s1 >= {2'b00, PRIME}) ? s1 - {2'b00, PRIME} : s1;
    end

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= BIT_W'(MOD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= s2[MOD_W-1:0];
            b_reg   <= {b_reg[MOD_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

// ----- design/mpr_dp.sv -----
`default_nettype none

module mpr_dp
    import mpr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire item_t   item,
    input  wire dp_cmd_t cmd,
    output dp_status_t   status,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    // count, prefix tree and factorial stores
    logic [CNT_W-1:0] cnt_mem  [0:SYM_DEPTH-1];
    logic [CNT_W-1:0] tree_mem [0:SYM_DEPTH-1];
    logic [MOD_W-1:0] fact_mem [0:MAX_LENGTH];

    logic [SYM_W-1:0] clr_idx_reg;
    logic [SYM_W-1:0] sym_reg;
    logic             cmd_reg;
    logic [SYM_W:0]   pos_reg;
    logic [CNT_W-1:0] acc_reg;
    logic [CNT_W-1:0] have_reg;
    logic [CNT_W-1:0] cnt_rd_reg;
    logic [CNT_W-1:0] tree_rd_reg;
    logic [MOD_W-1:0] fact_rd_reg;
    logic [MOD_W-1:0] den_reg;
    logic [MOD_W-1:0] inv_reg;
    logic [MOD_W-1:0] rank_reg;
    logic [MOD_W-1:0] term_reg;
    logic [MOD_W-1:0] fact_last_reg;
    logic [LEN_W-1:0] loaded_reg;
    logic [LEN_W-1:0] rem_reg;
    logic             started_reg;
    logic             stopped_reg;
    logic [BIT_W-1:0] ebit_reg;
    mul_sel_t         sel_reg;
    logic             result_valid_reg;
    result_t          result_reg;

    logic             is_clear;
    logic [SYM_W-1:0] mem_waddr;
    logic             cnt_we;
    logic [CNT_W-1:0] cnt_wdata;
    logic             tree_we;
    logic [CNT_W-1:0] tree_wdata;
    logic             fact_we;
    logic [LEN_W-1:0] fact_raddr;
    logic [MOD_W-1:0] fact_val;
    logic [SYM_W:0]   lowbit;
    logic             mul_start;
    logic [MOD_W-1:0] mul_a;
    logic [MOD_W-1:0] mul_b;
    logic             mul_done;
    logic [MOD_W-1:0] mul_p;
    logic [MOD_W:0]   rank_sum;
    logic [MOD_W-1:0] rank_add;
    logic [MOD_W-1:0] rank_inc;

    // shared modular multiplier
    mpr_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // address and write data selection
    always_comb
    begin
        is_clear   = (cmd.op == OP_CLEAR);
        lowbit     = pos_reg & (~pos_reg + 1'b1);
        mem_waddr  = is_clear ? clr_idx_reg : sym_reg;
        cnt_we     = is_clear || (cmd.op == OP_CNT_INC) || (cmd.op == OP_CNT_DEC);
        cnt_wdata  = '0;
        if (cmd.op == OP_CNT_INC)
        begin
            cnt_wdata = cnt_rd_reg + 1'b1;
        end
        else if (cmd.op == OP_CNT_DEC)
        begin
            cnt_wdata = have_reg - 1'b1;
        end
        tree_we    = is_clear || (cmd.op == OP_TREE_UPD);
        tree_wdata = '0;
        if (cmd.op == OP_TREE_UPD)
        begin
            tree_wdata = cmd_reg ? tree_rd_reg - 1'b1 : tree_rd_reg + 1'b1;
        end
        fact_we    = mul_done && (sel_reg == MS_FACT);
        fact_raddr = (rem_reg == '0) ? '0 : rem_reg - 1'b1;
        fact_val   = (rem_reg == LEN_W'(1)) ? MOD_W'(1) : fact_rd_reg;
    end

    // multiplier operand selection
    always_comb
    begin
        mul_start = (cmd.op == OP_MUL);
        mul_a     = inv_reg;
        mul_b     = inv_reg;
        case (cmd.mul_sel)
            MS_DEN:
            begin
                mul_a = den_reg;
                mul_b = MOD_W'(have_reg);
            end
            MS_FACT:
            begin
                mul_a = fact_last_reg;
                mul_b = MOD_W'(loaded_reg);
            end
            MS_SQ:
            begin
                mul_a = inv_reg;
                mul_b = inv_reg;
            end
            MS_BASE:
            begin
                mul_a = inv_reg;
                mul_b = den_reg;
            end
            MS_TERM1:
            begin
                mul_a = MOD_W'(acc_reg);
                mul_b = fact_val;
            end
            MS_TERM2:
            begin
                mul_a = term_reg;
                mul_b = inv_reg;
            end
            MS_INV:
            begin
                mul_a = inv_reg;
                mul_b = MOD_W'(have_reg);
            end
            default:
            begin
                mul_a = inv_reg;
                mul_b = inv_reg;
            end
        endcase
    end

    // modular add of a product, and the prefix bonus
    always_comb
    begin
        rank_sum = {1'b0, rank_reg} + {1'b0, mul_p};
        rank_add = (rank_sum >= {1'b0, PRIME}) ? MOD_W'(rank_sum - {1'b0, PRIME})
                                               : rank_sum[MOD_W-1:0];
        rank_inc = (rank_reg == PRIME - 1'b1) ? '0 : rank_reg + 1'b1;
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[mem_waddr] <= cnt_wdata;
        end
        if (cmd.op == OP_CNT_RD)
        begin
            cnt_rd_reg <= cnt_mem[sym_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tree_we)
        begin
            tree_mem[is_clear ? clr_idx_reg : pos_reg[SYM_W-1:0]] <= tree_wdata;
        end
        if (cmd.op == OP_TREE_RD)
        begin
            tree_rd_reg <= tree_mem[pos_reg[SYM_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fact_we)
        begin
            fact_mem[loaded_reg] <= mul_p;
        end
        if (cmd.op == OP_CNT_RD)
        begin
            fact_rd_reg <= fact_mem[fact_raddr];
        end
    end

    // control and accumulated state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg      <= '0;
            loaded_reg       <= '0;
            rem_reg          <= '0;
            started_reg      <= 1'b0;
            stopped_reg      <= 1'b0;
            den_reg          <= MOD_W'(1);
            rank_reg         <= '0;
            fact_last_reg    <= MOD_W'(1);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (is_clear)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.op == OP_CNT_INC)
            begin
                loaded_reg <= loaded_reg + 1'b1;
                rem_reg    <= rem_reg + 1'b1;
            end
            if (cmd.op == OP_CNT_DEC)
            begin
                rem_reg     <= rem_reg - 1'b1;
                started_reg <= 1'b1;
            end
            if (cmd.op == OP_STOP)
            begin
                stopped_reg <= 1'b1;
                started_reg <= 1'b1;
                if (rem_reg == '0)
                begin
                    rank_reg <= rank_inc;
                end
            end
            if (mul_done)
            begin
                case (sel_reg)
                    MS_DEN:   den_reg       <= mul_p;
                    MS_FACT:  fact_last_reg <= mul_p;
                    MS_TERM2: rank_reg      <= rank_add;
                    default:  ;
                endcase
            end
            if (cmd.op == OP_OUT)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                sym_reg <= item.symbol;
                cmd_reg <= item.command;
            end
            OP_CNT_INC:
            begin
                have_reg <= cnt_rd_reg + 1'b1;
                pos_reg  <= {1'b0, sym_reg};
            end
            OP_HAVE:     have_reg <= cnt_rd_reg;
            OP_CNT_DEC:  pos_reg  <= {1'b0, sym_reg};
            OP_TREE_UPD: pos_reg  <= pos_reg + lowbit;
            OP_SUM_INIT:
            begin
                pos_reg <= (sym_reg == '0) ? '0 : {1'b0, sym_reg} - 1'b1;
                acc_reg <= '0;
            end
            OP_SUM_ACC:
            begin
                acc_reg <= acc_reg + tree_rd_reg;
                pos_reg <= pos_reg - lowbit;
            end
            OP_POW_INIT:
            begin
                inv_reg  <= MOD_W'(1);
                ebit_reg <= BIT_W'(MOD_W - 1);
            end
            OP_EBIT_DEC: ebit_reg <= ebit_reg - 1'b1;
            OP_MUL:      sel_reg  <= cmd.mul_sel;
            OP_OUT:      result_reg <= '{rank: rank_reg, halted: stopped_reg};
            default:     ;
        endcase
        if (mul_done)
        begin
            case (sel_reg)
                MS_SQ, MS_BASE, MS_INV: inv_reg  <= mul_p;
                MS_TERM1:               term_reg <= mul_p;
                default:                ;
            endcase
        end
    end

    // status toward the controller
    always_comb
    begin
        status.clr_done  = (clr_idx_reg == '1);
        status.cmd       = cmd_reg;
        status.load_skip = stopped_reg || started_reg ||
                           (loaded_reg >= LEN_W'(MAX_LENGTH)) || (sym_reg == '0);
        status.stopped   = stopped_reg;
        status.started   = started_reg;
        status.pos_end   = pos_reg[SYM_W];
        status.pos_zero  = (pos_reg == '0);
        status.exp_bit   = EXP_INV[ebit_reg];
        status.ebit_zero = (ebit_reg == '0);
        status.term_go   = (rem_reg != '0) && (acc_reg != '0);
        status.have_zero = (have_reg == '0);
        status.mul_done  = mul_done;
        status.out_full  = result_valid_reg && result_stall;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- design/mpr_ctrl.sv -----
`default_nettype none

module mpr_ctrl
    import mpr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = OP_NONE;
        cmd.mul_sel = MS_DEN;
        item_stall  = (state_reg != S_IDLE);
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!status.cmd)
                begin
                    state_next = status.load_skip ? S_IDLE : S_L_CNT;
                end
                else if (status.stopped)
                begin
                    state_next = S_RESULT;
                end
                else if (!status.started)
                begin
                    cmd.op     = OP_POW_INIT;
                    state_next = S_PW_SQ;
                end
                else
                begin
                    state_next = S_T_SUM;
                end
            end
            // load transaction
            S_L_CNT:
            begin
                cmd.op     = OP_CNT_RD;
                state_next = S_L_INC;
            end
            S_L_INC:
            begin
                cmd.op     = OP_CNT_INC;
                state_next = S_L_MD;
            end
            S_L_MD:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_DEN;
                state_next  = S_L_MDW;
            end
            S_L_MDW:
            begin
                if (status.mul_done)
                begin
                    state_next = S_L_MF;
                end
            end
            S_L_MF:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_FACT;
                state_next  = S_L_MFW;
            end
            S_L_MFW:
            begin
                if (status.mul_done)
                begin
                    state_next = S_TR_RD;
                end
            end
            // prefix tree update walk, shared by load and target
            S_TR_RD:
            begin
                if (status.pos_end)
                begin
                    state_next = status.cmd ? S_RESULT : S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_TREE_RD;
                    state_next = S_TR_WR;
                end
            end
            S_TR_WR:
            begin
                cmd.op     = OP_TREE_UPD;
                state_next = S_TR_RD;
            end
            // inverse of the denominator, square and multiply
            S_PW_SQ:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_SQ;
                state_next  = S_PW_SQW;
            end
            S_PW_SQW:
            begin
                if (status.mul_done)
                begin
                    state_next = S_PW_CHK;
                end
            end
            S_PW_CHK:
            begin
                if (status.exp_bit)
                begin
                    cmd.op      = OP_MUL;
                    cmd.mul_sel = MS_BASE;
                    state_next  = S_PW_MLW;
                end
                else
                begin
                    state_next = S_PW_NX;
                end
            end
            S_PW_MLW:
            begin
                if (status.mul_done)
                begin
                    state_next = S_PW_NX;
                end
            end
            S_PW_NX:
            begin
                if (status.ebit_zero)
                begin
                    state_next = S_T_SUM;
                end
                else
                begin
                    cmd.op     = OP_EBIT_DEC;
                    state_next = S_PW_SQ;
                end
            end
            // target transaction: count smaller symbols
            S_T_SUM:
            begin
                cmd.op     = OP_SUM_INIT;
                state_next = S_T_SRD;
            end
            S_T_SRD:
            begin
                if (status.pos_zero)
                begin
                    state_next = S_T_CNT;
                end
                else
                begin
                    cmd.op     = OP_TREE_RD;
                    state_next = S_T_SACC;
                end
            end
            S_T_SACC:
            begin
                cmd.op     = OP_SUM_ACC;
                state_next = S_T_SRD;
            end
            S_T_CNT:
            begin
                cmd.op     = OP_CNT_RD;
                state_next = S_T_HAVE;
            end
            S_T_HAVE:
            begin
                cmd.op     = OP_HAVE;
                state_next = S_T_TERM;
            end
            // term = smaller * fact * inverse
            S_T_TERM:
            begin
                if (status.term_go)
                begin
                    cmd.op      = OP_MUL;
                    cmd.mul_sel = MS_TERM1;
                    state_next  = S_T_T1W;
                end
                else
                begin
                    state_next = S_T_UPD;
                end
            end
            S_T_T1W:
            begin
                if (status.mul_done)
                begin
                    state_next = S_T_T2;
                end
            end
            S_T_T2:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_TERM2;
                state_next  = S_T_T2W;
            end
            S_T_T2W:
            begin
                if (status.mul_done)
                begin
                    state_next = S_T_UPD;
                end
            end
            // remove the symbol or halt
            S_T_UPD:
            begin
                if (status.have_zero)
                begin
                    cmd.op     = OP_STOP;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = OP_CNT_DEC;
                    state_next = S_T_INV;
                end
            end
            S_T_INV:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_INV;
                state_next  = S_T_INVW;
            end
            S_T_INVW:
            begin
                if (status.mul_done)
                begin
                    state_next = S_TR_RD;
                end
            end
            S_RESULT:
            begin
                if (!status.out_full)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/multiset_permutation_rank.sv -----
// channel  | direction | payload                    | handshake
// item     | in        | command, symbol, last      | item_valid / item_stall
// result   | out       | rank, halted               | result_valid / result_stall
//
// after reset the count and prefix tree stores are cleared, one entry a cycle,
// with item_stall high. a load transaction runs two modular products on the
// shared bit-serial multiplier plus a prefix tree walk that reads and updates
// each level. a target transaction runs a tree sum, up to three products and a
// tree walk; the first one adds the Fermat inverse. a target after halting goes
// straight to the result; one transaction is in work at a time, and a finished
// result waits in the output register while the next is taken.
`default_nettype none

module multiset_permutation_rank
    import mpr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_stall,
    output result_t    result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mpr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    mpr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- design/mpr_checker.sv -----
`default_nettype none

module mpr_checker
    import mpr_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_stall,
    input wire item_t   item,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    logic             halt_seen_reg;
    logic [MOD_W-1:0] rank_seen_reg;

    // remember the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_seen_reg <= 1'b0;
            rank_seen_reg <= '0;
        end
        else if (result_valid && !result_stall)
        begin
            halt_seen_reg <= result.halted;
            rank_seen_reg <= result.rank;
        end
    end

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // rank is reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.rank < PRIME)
        else $error("rank not reduced");

    // halting is permanent
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && halt_seen_reg |-> result.halted)
        else $error("halted flag dropped");

    // rank frozen after halting
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && halt_seen_reg |-> result.rank == rank_seen_reg)
        else $error("rank changed after halt");

endmodule

bind multiset_permutation_rank mpr_checker u_mpr_checker (.*);

`default_nettype wire
